/* sv/rcl_pkg.sv */
// ============================================================================
// rcl_pkg
// Shared types, constants and helpers for the rainbow chase LED pattern unit.
// ============================================================================
package rcl_pkg;

  // String geometry and divider range
  localparam int LED_COUNT  = 64;
  localparam int SPEED_MAX  = 15;
  localparam int HEAD_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int IDX_W      = 6;
  localparam int SUM_W      = ((HEAD_W > IDX_W) ? HEAD_W : IDX_W) + 1;
  localparam int CH_W       = 8;
  localparam int DIV_W      = 5;
  localparam int SPEED_W    = 4;
  localparam int FADE_W     = 3;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CH_W-1:0] TOP_LEVEL = 8'd240;

  // Register reset values
  localparam logic [SPEED_W-1:0] SPEED_RST = 4'd15;
  localparam logic [FADE_W-1:0]  FADE_RST  = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED = 1'b0,
    REG_FADE  = 1'b1
  } reg_e;

  // Sequencer phases; code 7 is unreachable
  typedef enum logic [2:0] {
    PH_RED_UP  = 3'd0,
    PH_GRN_UP  = 3'd1,
    PH_RED_DN  = 3'd2,
    PH_BLU_UP  = 3'd3,
    PH_GRN_DN  = 3'd4,
    PH_RED_UP2 = 3'd5,
    PH_BLU_DN  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] pixel_index;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            advanced;
  } out_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [FADE_W-1:0]  fade_select;
  } cfg_t;

  // Sequencer to datapath: advance flag, write slot and head colour
  typedef struct packed {
    logic              advance;
    logic [HEAD_W-1:0] waddr;
    pix_t              colour;
  } seq_t;

  function automatic logic [CH_W-1:0] fade_step(input logic [FADE_W-1:0] sel);
    logic [CH_W-1:0] step;
    case (sel)
      3'd0:    step = 8'd10;
      3'd1:    step = 8'd20;
      3'd2:    step = 8'd40;
      3'd3:    step = 8'd60;
      default: step = 8'd80;
    endcase
    return step;
  endfunction

endpackage

/* sv/rcl_chain_ram.sv */
// ============================================================================
// rcl_chain_ram
// Pixel chain ring storage: one write port, one registered read port, and a
// valid bit per slot so a restart empties the whole chain at once.
// ============================================================================
module rcl_chain_ram
  import rcl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [HEAD_W-1:0] waddr_i,
  input  pix_t              wdata_i,
  input  logic              clr_i,
  input  logic              re_i,
  input  logic [HEAD_W-1:0] raddr_i,
  output pix_t              rdata_o
);

  pix_t                 mem [LED_COUNT];
  pix_t                 rdata_q;
  logic [LED_COUNT-1:0] vld_q;
  logic                 rvld_q;

  // Data array, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Slot valid bits; an empty slot reads as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

/* sv/rcl_sequencer.sv */
// ============================================================================
// rcl_sequencer
// Speed divider, seven-phase colour ramp and ring head pointer. Computes the
// outcome of a tick combinationally and commits it when the tick is taken.
// ============================================================================
module rcl_sequencer
  import rcl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic              restart_i,
  input  cfg_t              cfg_i,
  output seq_t              seq_o,
  output logic [HEAD_W-1:0] head_o
);

  logic [DIV_W-1:0]  div_q;
  phase_e            phase_q, phase_d;
  pix_t              col_q, col_d;
  logic [HEAD_W-1:0] head_q, head_dec;

  logic [DIV_W-1:0]  limit;
  logic [DIV_W:0]    cnt;
  logic              advance;

  logic [CH_W-1:0]   step, ch, new_ch;
  logic [CH_W:0]     up_sum;
  logic              up, at_end, ph_ok;
  chan_e             sel;
  phase_e            ph_nxt;

  // Divider threshold; a speed above the maximum advances on every tick
  always_comb begin
    if (int'(cfg_i.speed) <= SPEED_MAX) begin
      limit = DIV_W'(SPEED_MAX - int'(cfg_i.speed));
    end else begin
      limit = '0;
    end
    cnt     = {1'b0, div_q} + 1'b1;
    advance = cnt > {1'b0, limit};
  end

  // Phase decode: which channel moves, which way, and the following phase
  always_comb begin
    sel    = CH_RED;
    up     = 1'b1;
    ph_nxt = phase_q;
    ph_ok  = 1'b1;
    case (phase_q)
      PH_RED_UP: begin
        sel = CH_RED;   up = 1'b1; ph_nxt = PH_GRN_UP;
      end
      PH_GRN_UP: begin
        sel = CH_GREEN; up = 1'b1; ph_nxt = PH_RED_DN;
      end
      PH_RED_DN: begin
        sel = CH_RED;   up = 1'b0; ph_nxt = PH_BLU_UP;
      end
      PH_BLU_UP: begin
        sel = CH_BLUE;  up = 1'b1; ph_nxt = PH_GRN_DN;
      end
      PH_GRN_DN: begin
        sel = CH_GREEN; up = 1'b0; ph_nxt = PH_RED_UP2;
      end
      PH_RED_UP2: begin
        sel = CH_RED;   up = 1'b1; ph_nxt = PH_BLU_DN;
      end
      PH_BLU_DN: begin
        sel = CH_BLUE;  up = 1'b0; ph_nxt = PH_GRN_UP;
      end
      default: begin
        ph_ok = 1'b0;
      end
    endcase
  end

  // Ramp one channel with clamping at both ends
  always_comb begin
    step = fade_step(cfg_i.fade_select);
    case (sel)
      CH_RED:   ch = col_q.red;
      CH_GREEN: ch = col_q.green;
      CH_BLUE:  ch = col_q.blue;
      default:  ch = col_q.red;
    endcase
    up_sum = {1'b0, ch} + {1'b0, step};
    if (up) begin
      at_end = ch >= TOP_LEVEL;
      new_ch = (up_sum > {1'b0, TOP_LEVEL}) ? TOP_LEVEL : up_sum[CH_W-1:0];
    end else begin
      at_end = ch == '0;
      new_ch = (ch > step) ? ch - step : '0;
    end
  end

  // Colour and phase after an advance
  always_comb begin
    col_d   = col_q;
    phase_d = phase_q;
    if (ph_ok) begin
      if (at_end) begin
        phase_d = ph_nxt;
      end else begin
        case (sel)
          CH_RED:   col_d.red   = new_ch;
          CH_GREEN: col_d.green = new_ch;
          CH_BLUE:  col_d.blue  = new_ch;
          default:  col_d       = col_q;
        endcase
      end
    end
  end

  // Ring head moves one slot back on each advance
  assign head_dec = (head_q == '0) ? HEAD_W'(LED_COUNT - 1) : head_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= '0;
      phase_q <= PH_RED_UP;
      col_q   <= '0;
      head_q  <= '0;
    end else if (restart_i) begin
      div_q   <= '0;
      phase_q <= PH_RED_UP;
      col_q   <= '0;
      head_q  <= '0;
    end else if (tick_i) begin
      if (advance) begin
        div_q   <= '0;
        phase_q <= phase_d;
        col_q   <= col_d;
        head_q  <= head_dec;
      end else begin
        div_q   <= cnt[DIV_W-1:0];
      end
    end
  end

  // The head slot always holds the current colour
  assign seq_o.advance = advance;
  assign seq_o.waddr   = head_dec;
  assign seq_o.colour  = advance ? col_d : col_q;
  assign head_o        = head_q;

endmodule

/* sv/rainbow_chase_led_pattern_unit.sv */
// ============================================================================
// rainbow_chase_led_pattern_unit
// Rainbow chase generator for an addressable LED string: ticks, restarts and
// pixel reads in, one colour transaction out for each transaction in.
// ============================================================================
//
//  channel | dir | handshake                   | payload
//  --------+-----+-----------------------------+---------------------------
//  in      | in  | in_valid_i / in_ready_o     | in_data_i  (command, index)
//  out     | out | out_valid_o / out_ready_i   | out_data_o (r, g, b, adv)
//  cfg     | in  | cfg_we_i, no wait           | cfg_idx_i, cfg_data_i
//
//  One transaction per cycle while out_ready_i is high; input passes the
//  registered read port of the chain memory, then the output register.
//  Ticks and restarts commit their state in the cycle they are taken; a read
//  sees every earlier write, so no forwarding is needed.
//  Restart and reset empty the chain at once through per-slot valid bits.
//  With out_ready_i low, one transaction waits in the output register and one
//  more in the read stage before in_ready_o drops.
//
module rainbow_chase_led_pattern_unit
  import rcl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              in_acc, tick, restart, rd, idx_ok, re;
  cmd_e              cmd;
  seq_t              seq;
  logic [HEAD_W-1:0] head, raddr;
  logic [SUM_W-1:0]  sum, wrapped;
  pix_t              ram_rdata;

  logic              s1_valid_q, s1_mem_q, s1_adv_q, s1_move;
  pix_t              s1_pix_q;
  logic              out_valid_q;
  out_t              out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed       <= SPEED_RST;
      cfg_q.fade_select <= FADE_RST;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_SPEED: cfg_q.speed       <= cfg_data_i[SPEED_W-1:0];
        REG_FADE:  cfg_q.fade_select <= cfg_data_i[FADE_W-1:0];
        default:   cfg_q             <= cfg_q;
      endcase
    end
  end

  // Command decode
  assign in_acc  = in_valid_i && in_ready_o;
  assign cmd     = cmd_e'(in_data_i.command);
  assign tick    = in_acc && (cmd == CMD_TICK);
  assign restart = in_acc && (cmd == CMD_RESTART);
  assign rd      = in_acc && (cmd == CMD_READ);

  // Read address: ring position head + index
  assign idx_ok  = SUM_W'(in_data_i.pixel_index) < SUM_W'(LED_COUNT);
  assign sum     = SUM_W'(head) + SUM_W'(in_data_i.pixel_index);
  assign wrapped = (sum >= SUM_W'(LED_COUNT)) ? sum - SUM_W'(LED_COUNT) : sum;
  assign raddr   = wrapped[HEAD_W-1:0];
  assign re      = rd && idx_ok;

  rcl_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .restart_i (restart),
    .cfg_i     (cfg_q),
    .seq_o     (seq),
    .head_o    (head)
  );

  rcl_chain_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tick && seq.advance),
    .waddr_i (seq.waddr),
    .wdata_i (seq.colour),
    .clr_i   (restart),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Pipeline flow: read stage feeds the output register
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mem_q <= re;
      s1_adv_q <= tick && seq.advance;
      s1_pix_q <= tick ? seq.colour : '0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      if (s1_mem_q) begin
        out_q.red   <= ram_rdata.red;
        out_q.green <= ram_rdata.green;
        out_q.blue  <= ram_rdata.blue;
      end else begin
        out_q.red   <= s1_pix_q.red;
        out_q.green <= s1_pix_q.green;
        out_q.blue  <= s1_pix_q.blue;
      end
      out_q.advanced <= s1_adv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/rcl_checker.sv */
// ============================================================================
// rcl_checker
// Port-level checks for the rainbow chase unit, bound to the top level.
// ============================================================================
module rcl_checker
  import rcl_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input in_t                   in_data_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input out_t                  out_data_o,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // A stalled output transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // A stalled output payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // The input side only stalls behind a stalled output
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with output free");

  // A fresh output follows an input transaction through the read stage
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output transaction without matching input");

endmodule

bind rainbow_chase_led_pattern_unit rcl_checker u_rcl_checker (.*);
